// ----- sv/prac_pkg.sv -----
`default_nettype none

package prac_pkg;

   localparam int unsigned NUM_REGIONS = 8;
   localparam int unsigned ADDR_W      = 32;
   localparam int unsigned CSR_ADDR_W  = 6;
   localparam int unsigned CSR_DATA_W  = 64;
   localparam int unsigned MIN_SIZE_BIT = 6;

   localparam logic [31:0] PERM_RESET = 32'h2222_2222;

   // bit c set: permission code c grants the access
   localparam logic [15:0] DATA_READ_SYS  = 16'h006E;
   localparam logic [15:0] DATA_READ_USR  = 16'h004C;
   localparam logic [15:0] DATA_WRITE_SYS = 16'h000E;
   localparam logic [15:0] DATA_WRITE_USR = 16'h0008;
   localparam logic [15:0] CODE_EXEC_SYS  = 16'h004E;
   localparam logic [15:0] CODE_EXEC_USR  = 16'h004C;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_EXEC  = 2'd2
   } access_kind_type;

   typedef enum logic [2:0] {
      REG_ENABLE    = 3'd0,
      REG_DATA_PERM = 3'd1,
      REG_CODE_PERM = 3'd2,
      REG_REGION01  = 3'd3,
      REG_REGION23  = 3'd4,
      REG_REGION45  = 3'd5,
      REG_REGION67  = 3'd6
   } reg_index_type;

   // Size id 31 leaves the mask empty, so the region covers everything.
   function automatic logic region_hit(input logic [31:0] word, input logic [31:0] addr);
      logic [31:0] mask;
      for (int i = 0; i < 32; i++) begin
         mask[i] = (i >= MIN_SIZE_BIT) && (5'(i) > word[5:1]);
      end
      return word[0] && (((addr ^ word) & mask) == 32'd0);
   endfunction

endpackage

`default_nettype wire

// ----- sv/protection_region_access_check.sv -----
`default_nettype none
// Eight-region memory protection check.
// req_ channel: one access (address, kind, privilege) per transfer.
// rsp_ channel: one allowed flag per access, in order.
// csr_ port: APB-style, 64-bit data, register i at byte address 8*i
//   (enable, data permissions, code permissions, four region pairs).
//   Writes complete in the access cycle; pready is tied high.
// Path: an access goes to the input register, then the result register.
// Throughput: one access per cycle while rsp_ready is high; the
//   region compare and permission lookup for all eight regions sit
//   between the input register and the result register.
// Stalls: when rsp_ready is low the result holds; the input register
//   still takes one more access, then req_ready drops until the
//   result is taken.
// Reset: both pipeline registers empty, protection off, permissions
//   0x22222222, all regions disabled.
module protection_region_access_check
   import prac_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    csr_psel,
   input  wire                    csr_penable,
   input  wire                    csr_pwrite,
   input  wire [CSR_ADDR_W-1:0]   csr_paddr,
   input  wire [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire [ADDR_W-1:0]       req_address,
   input  wire [1:0]              req_access_kind,
   input  wire                    req_privileged,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output logic                   rsp_allowed
);

   logic              enable_ff;
   logic [31:0]       data_perm_ff;
   logic [31:0]       code_perm_ff;
   logic [63:0]       pair_ff [4];

   logic              s1_valid_ff, s1_valid_in;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [1:0]        s1_kind_ff;
   logic              s1_priv_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_allowed_ff, rsp_allowed_in;

   logic              csr_write;
   reg_index_type     csr_index;
   logic              s1_advance;
   logic              req_take;
   logic [15:0]       grant_set;
   logic [31:0]       perms;
   logic [NUM_REGIONS-1:0] region_grant;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         data_perm_ff <= PERM_RESET;
         code_perm_ff <= PERM_RESET;
         for (int p = 0; p < 4; p++) begin
            pair_ff[p] <= 64'd0;
         end
      end else if (csr_write) begin
         unique case (csr_index)
            REG_ENABLE:    enable_ff    <= csr_pwdata[0];
            REG_DATA_PERM: data_perm_ff <= csr_pwdata[31:0];
            REG_CODE_PERM: code_perm_ff <= csr_pwdata[31:0];
            REG_REGION01:  pair_ff[0]   <= csr_pwdata;
            REG_REGION23:  pair_ff[1]   <= csr_pwdata;
            REG_REGION45:  pair_ff[2]   <= csr_pwdata;
            REG_REGION67:  pair_ff[3]   <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_ENABLE:    csr_prdata = {63'd0, enable_ff};
         REG_DATA_PERM: csr_prdata = {32'd0, data_perm_ff};
         REG_CODE_PERM: csr_prdata = {32'd0, code_perm_ff};
         REG_REGION01:  csr_prdata = pair_ff[0];
         REG_REGION23:  csr_prdata = pair_ff[1];
         REG_REGION45:  csr_prdata = pair_ff[2];
         REG_REGION67:  csr_prdata = pair_ff[3];
         default:       csr_prdata = '0;
      endcase
   end

   // pipeline control
   assign s1_advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !s1_valid_ff || s1_advance;
   assign req_take     = req_valid && req_ready;
   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = s1_advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_addr_ff <= req_address;
         s1_kind_ff <= req_access_kind;
         s1_priv_ff <= req_privileged;
      end
      if (s1_advance) begin
         rsp_allowed_ff <= rsp_allowed_in;
      end
   end

   // region check
   always_comb begin
      unique case (access_kind_type'(s1_kind_ff))
         KIND_READ: begin
            grant_set = s1_priv_ff ? DATA_READ_SYS : DATA_READ_USR;
            perms     = data_perm_ff;
         end
         KIND_WRITE: begin
            grant_set = s1_priv_ff ? DATA_WRITE_SYS : DATA_WRITE_USR;
            perms     = data_perm_ff;
         end
         KIND_EXEC: begin
            grant_set = s1_priv_ff ? CODE_EXEC_SYS : CODE_EXEC_USR;
            perms     = code_perm_ff;
         end
         default: begin
            grant_set = 16'd0;
            perms     = 32'd0;
         end
      endcase
      for (int n = 0; n < NUM_REGIONS; n++) begin
         region_grant[n] = grant_set[perms[4*n +: 4]]
            && region_hit(pair_ff[n/2][32*(n%2) +: 32], s1_addr_ff);
      end
      rsp_allowed_in = !enable_ff || (|region_grant);
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_allowed = rsp_allowed_ff;

endmodule

`default_nettype wire

// ----- sv/prac_checker.sv -----
`default_nettype none

module prac_checker
   import prac_pkg::*;
(
   input wire                   clock,
   input wire                   reset,
   input wire                   csr_psel,
   input wire                   csr_penable,
   input wire                   csr_pwrite,
   input wire [CSR_ADDR_W-1:0]  csr_paddr,
   input wire [CSR_DATA_W-1:0]  csr_pwdata,
   input wire [CSR_DATA_W-1:0]  csr_prdata,
   input wire                   req_ready,
   input wire                   rsp_valid,
   input wire                   rsp_ready,
   input wire                   rsp_allowed
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_allowed))
      else $error("stalled result changed or dropped");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result stage");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   a_enable_read: assert property (@(posedge clock) disable iff (reset)
      csr_psel && !csr_pwrite && csr_paddr[CSR_ADDR_W-1:3] == REG_ENABLE
      |-> csr_prdata[CSR_DATA_W-1:1] == '0)
      else $error("enable register reads stray bits");

   a_perm_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_paddr[CSR_ADDR_W-1:3] == REG_DATA_PERM
      ##1 csr_psel && !csr_pwrite && csr_paddr[CSR_ADDR_W-1:3] == REG_DATA_PERM
      |-> csr_prdata[31:0] == $past(csr_pwdata[31:0]))
      else $error("data permission readback mismatch");

endmodule

bind protection_region_access_check prac_checker u_prac_checker (
   .clock       (clock),
   .reset       (reset),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_allowed (rsp_allowed)
);

`default_nettype wire
